### rtl/lzss_stream_encoder_assert.svh
// assertion macros used by the lzss encoder datapath (lzss_dpath)
// expects clk and arst_n in the scope of each use
`ifndef LZSS_STREAM_ENCODER_ASSERT_SVH
`define LZSS_STREAM_ENCODER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define LZSS_ASSERT_NOW(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define LZSS_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/lzss_pkg.sv
// shared types and constants of the lzss stream encoder
// used by lzss_ctrl, lzss_dpath and lzss_stream_encoder
package lzss_pkg;

	localparam logic [7:0] FILL_RESET    = 8'd32;
	localparam logic       REG_FILL_BYTE = 1'b0;
	localparam int         LIT_BITS      = 8;

	// commands from the controller to the datapath
	typedef struct packed {
		logic take;
		logic ld_start;
		logic ld_step;
		logic sc_step;
		logic build;
		logic emit;
		logic pad;
		logic close;
	} lzss_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic tok_ready;
		logic flush;
		logic ld_last;
		logic sc_last;
		logic emit_end;
		logic out_free;
		logic bits_pending;
	} lzss_sts_t;

endpackage

### rtl/lzss_ctrl.sv
// sequencing state machine of the lzss encoder
// depends on lzss_pkg command and status types
module lzss_ctrl import lzss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  lzss_sts_t sts,
	output lzss_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_DECIDE, ST_LOAD, ST_SCAN, ST_DRAIN, ST_BUILD, ST_EMIT, ST_PAD
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				priority if (sts.tok_ready) begin
					cmd.ld_start = 1'b1;
					state_d = ST_LOAD;
				end else if (sts.flush && sts.bits_pending) begin
					state_d = ST_PAD;
				end else if (sts.flush) begin
					cmd.close = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_LOAD: begin
				cmd.ld_step = 1'b1;
				if (sts.ld_last) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.sc_step = 1'b1;
				if (sts.sc_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_BUILD;
			ST_BUILD: begin
				cmd.build = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_end) state_d = ST_DECIDE;
			end
			ST_PAD: begin
				cmd.pad = 1'b1;
				if (sts.out_free) begin
					cmd.close = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/lzss_dpath.sv
// window memory, match lanes, bit packer and output register of the encoder
// depends on lzss_pkg and lzss_stream_encoder_assert.svh
`include "lzss_stream_encoder_assert.svh"
module lzss_dpath import lzss_pkg::*; #(
	parameter int WINDOW_BITS = 11,
	parameter int LENGTH_BITS = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  lzss_cmd_t  cmd,
	output lzss_sts_t  sts,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic [7:0] fill_byte,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       out_last
);

	localparam int WIN   = 1 << WINDOW_BITS;
	localparam int LOOK  = (1 << LENGTH_BITS) + 1;
	localparam int STORE = 2 * WIN;
	localparam int AW    = WINDOW_BITS + 1;
	localparam int HIST  = WIN - LOOK;
	localparam int LW    = LENGTH_BITS + 1;
	localparam int CW    = 1 + WINDOW_BITS + LENGTH_BITS;
	localparam int RW    = $clog2(CW + 1);

	logic [7:0]             mem [STORE];
	logic [7:0]             rd_s1;
	logic [AW-1:0]          fp_q, r_q, cnt_q;
	logic [AW:0]            wr_cnt_q;
	logic [7:0]             fill_snap_q;
	logic                   open_q, flush_q;
	logic [LW-1:0]          avail_q;
	logic                   ld_v_s1, sc_v_s1, start_s1, fill_s1;
	logic [LW-1:0]          idx_s1;
	logic [AW-1:0]          k_s1;
	logic [7:0]             la_q [LOOK];
	logic [LOOK-1:1]        act_q;
	logic [LOOK-1:1]        act_d;
	logic [LW-1:0]          best_len_q;
	logic [WINDOW_BITS-1:0] best_pos_q;
	logic [CW-1:0]          code_q;
	logic [RW-1:0]          rem_q;
	logic                   final_q;
	logic [7:0]             acc_q;
	logic [2:0]             bf_q;
	logic                   out_valid_q, out_last_q;
	logic [7:0]             out_byte_q;

	logic [AW-1:0]          waiting, rd_addr, r_new, wr_addr;
	logic [LW-1:0]          avail_d, step;
	logic                   rd_fill, out_free, can_shift, emit_fire, byte_fire, pad_fire;
	logic                   lit, hit;
	logic [LW-1:0]          hit_len;
	logic [WINDOW_BITS-1:0] hit_pos;
	logic [7:0]             win_byte, acc_next;
	logic [LOOK-1:0]        lane_v, lane_eq;

	assign waiting  = fp_q - r_q;
	assign avail_d  = (waiting >= AW'(LOOK)) ? LW'(LOOK) : waiting[LW-1:0];
	assign rd_addr  = cmd.ld_step ? (r_q + cnt_q) : (r_q - AW'(HIST) + cnt_q);
	// entries below the history start hold the fill byte until the writes wrap onto them
	assign rd_fill  = (rd_addr < AW'(HIST)) &&
		(({1'b0, rd_addr} + (AW+1)'(STORE - HIST)) >= wr_cnt_q);
	assign wr_addr  = open_q ? fp_q : AW'(HIST);
	assign win_byte = fill_s1 ? fill_snap_q : rd_s1;

	assign out_free  = !out_valid_q || !out_stall;
	assign can_shift = (bf_q != 3'd7) || out_free;
	assign emit_fire = cmd.emit && can_shift;
	assign byte_fire = emit_fire && (bf_q == 3'd7);
	assign pad_fire  = cmd.pad && out_free;
	assign acc_next  = acc_q | ({code_q[CW-1], 7'b0} >> bf_q);

	assign lit   = (best_len_q <= LW'(1));
	assign step  = lit ? LW'(1) : best_len_q;
	assign r_new = r_q + {{(AW-LW){1'b0}}, step};

	assign sts.tok_ready    = (waiting >= AW'(LOOK)) || (flush_q && (waiting != '0));
	assign sts.flush        = flush_q;
	assign sts.ld_last      = (cnt_q == ({{(AW-LW){1'b0}}, avail_q} - AW'(1)));
	assign sts.sc_last      = (cnt_q == (AW'(HIST) + {{(AW-LW){1'b0}}, avail_q} - AW'(2)));
	assign sts.emit_end     = emit_fire && (rem_q == RW'(1));
	assign sts.out_free     = out_free;
	assign sts.bits_pending = (bf_q != 3'd0);

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// one lane per matched length; lane 0 opens a new candidate
	always_comb begin
		lane_v  = {act_q, start_s1};
		act_d   = '0;
		hit     = 1'b0;
		hit_len = '0;
		hit_pos = '0;
		for (int j = 0; j < LOOK; j++) begin
			lane_eq[j] = (win_byte == la_q[j]);
			if (lane_v[j] && lane_eq[j] && (LW'(j + 1) == avail_q)) begin
				hit     = 1'b1;
				hit_len = avail_q;
				hit_pos = k_s1[WINDOW_BITS-1:0] - WINDOW_BITS'(j);
			end else if (lane_v[j] && !lane_eq[j] && (j >= 2)) begin
				hit     = 1'b1;
				hit_len = LW'(j);
				hit_pos = k_s1[WINDOW_BITS-1:0] - WINDOW_BITS'(j);
			end
			if (j < LOOK - 1) begin
				if (lane_v[j] && lane_eq[j] && (LW'(j + 1) < avail_q)) act_d[j+1] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) mem[wr_addr] <= in_byte;
		if (cmd.ld_step || cmd.sc_step) rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take && !open_q) fill_snap_q <= fill_byte;
		idx_s1   <= cnt_q[LW-1:0];
		k_s1     <= rd_addr;
		fill_s1  <= rd_fill;
		start_s1 <= cmd.sc_step && (cnt_q < AW'(HIST));
		if (ld_v_s1) la_q[idx_s1] <= win_byte;
		if (cmd.ld_start) begin
			avail_q    <= avail_d;
			best_len_q <= LW'(1);
			best_pos_q <= '0;
		end else if (sc_v_s1 && hit && (hit_len >= best_len_q)) begin
			best_len_q <= hit_len;
			best_pos_q <= hit_pos;
		end
		if (cmd.build) begin
			code_q  <= lit ? {1'b1, la_q[0], {(CW-LIT_BITS-1){1'b0}}}
				: {1'b0, best_pos_q, LENGTH_BITS'(best_len_q - LW'(2))};
			rem_q   <= lit ? RW'(LIT_BITS + 1) : RW'(CW);
			final_q <= flush_q && (fp_q == r_new);
		end else if (emit_fire) begin
			code_q <= code_q << 1;
			rem_q  <= rem_q - RW'(1);
		end
		if (byte_fire) begin
			out_byte_q <= acc_next;
			out_last_q <= final_q && (rem_q == RW'(1));
		end else if (pad_fire) begin
			out_byte_q <= acc_q;
			out_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q        <= AW'(HIST);
			r_q         <= AW'(HIST);
			wr_cnt_q    <= '0;
			open_q      <= 1'b0;
			flush_q     <= 1'b0;
			cnt_q       <= '0;
			ld_v_s1     <= 1'b0;
			sc_v_s1     <= 1'b0;
			act_q       <= '0;
			acc_q       <= '0;
			bf_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ld_v_s1 <= cmd.ld_step;
			sc_v_s1 <= cmd.sc_step;
			if (cmd.take) begin
				flush_q <= in_last;
				open_q  <= 1'b1;
				if (!open_q) begin
					// new stream starts over on a fresh window
					fp_q     <= AW'(HIST + 1);
					r_q      <= AW'(HIST);
					wr_cnt_q <= (AW+1)'(1);
					acc_q    <= '0;
					bf_q     <= '0;
				end else begin
					fp_q <= fp_q + AW'(1);
					if (wr_cnt_q != (AW+1)'(STORE)) wr_cnt_q <= wr_cnt_q + (AW+1)'(1);
				end
			end
			if (cmd.close) open_q <= 1'b0;
			priority if (cmd.ld_start) begin
				cnt_q <= '0;
			end else if (cmd.ld_step && sts.ld_last) begin
				cnt_q <= '0;
			end else if (cmd.ld_step || cmd.sc_step) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (cmd.ld_start) begin
				act_q <= '0;
			end else if (sc_v_s1) begin
				act_q <= act_d;
			end
			if (cmd.build) r_q <= r_new;
			if (byte_fire || pad_fire) begin
				acc_q <= '0;
				bf_q  <= '0;
			end else if (emit_fire) begin
				acc_q <= acc_next;
				bf_q  <= bf_q + 3'd1;
			end
			if (byte_fire || pad_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`LZSS_ASSERT_NOW(a_no_overwrite, out_valid_q && out_stall, !byte_fire && !pad_fire, "output byte overwritten while stalled")
	`LZSS_ASSERT_NOW(a_best_in_range, sc_v_s1, best_len_q <= avail_q, "match length beyond lookahead")
	`LZSS_ASSERT_NOW(a_look_room, cmd.take && open_q, waiting < AW'(LOOK), "lookahead overflow on new byte")
	`LZSS_ASSERT_NEXT(a_byte_shown, byte_fire, out_valid_q, "completed byte not presented")

endmodule

### rtl/lzss_stream_encoder.sv
// lzss stream encoder top level: config register and controller/datapath pair
// depends on lzss_pkg, lzss_ctrl and lzss_dpath
//
// Input channel in_valid/in_stall carries one raw byte (in_byte) with in_last on
// the final byte of a stream. Output channel out_valid/out_stall carries packed
// code bytes, MSB first, with out_last on the final byte of each stream.
// One register, fill_byte (address 0), is to be written over the APB port only
// while the block is idle; the block itself does not enforce this. It takes
// effect at the next stream start. A byte that fills the lookahead costs one
// token: the take and decide steps, then with the input stalled a lookahead
// load, a window scan (one window position per cycle through the single memory
// read port), a drain and a build step, and one code bit (9 or 17) per cycle
// unless output stalls. Other bytes need only take and decide. The last byte
// codes every waiting byte, one token after another, then pads a partial byte.
// After reset fill_byte is 32 and the next byte starts a stream; the window
// needs no clearing pass. A stalled receiver holds one finished byte in the
// output register; coding halts when a further byte would complete.
module lzss_stream_encoder import lzss_pkg::*; #(
	parameter int WINDOW_BITS = 11,
	parameter int LENGTH_BITS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        out_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	lzss_cmd_t  cmd;
	lzss_sts_t  sts;
	logic [7:0] fill_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FILL_BYTE) ? {24'b0, fill_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= FILL_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_FILL_BYTE)) begin
			fill_q <= pwdata[7:0];
		end
	end

	lzss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzss_dpath #(
		.WINDOW_BITS (WINDOW_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.fill_byte (fill_q),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule
